// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files that check their own logic.
// Depends on signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define FLC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define FLC_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/flc_pkg.sv
// Shared types and constants of the convolution unit.
// No dependencies; imported by the top, front and back modules.
package flc_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 6;
	localparam int LEN_W  = 6;

	typedef enum logic [1:0] {
		FN_LOAD_F = 2'd0,
		FN_LOAD_G = 2'd1,
		FN_RUN    = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		CMD_WR_F = 2'd0,
		CMD_WR_G = 2'd1,
		CMD_RUN  = 2'd2
	} cmd_kind_t;

	// arg_a: write index, or first length for a run; arg_b: second length
	typedef struct packed {
		cmd_kind_t         kind;
		logic [DATA_W-1:0] data;
		logic [LEN_W-1:0]  arg_a;
		logic [LEN_W-1:0]  arg_b;
	} cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] sum;
		logic [POS_W-1:0]  position;
		logic              last;
	} res_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} back_state_t;

endpackage

// File: rtl/full_linear_convolution_unit.sv
// Full 1-D linear convolution unit: front end, command queue, MAC back end,
// result queue. Depends on flc_pkg, flc_front, flc_fifo, flc_back and
// assert_macros.svh.
//
// Input channel (push/full): func 0 appends sample to the first sequence,
// func 1 to the second, func 2 runs the convolution, func 3 is dropped.
// Appends past MAX_LEN are dropped. A run emits first+second-1 results in
// position order, last set on the final one, then clears both lengths; a run
// with an empty sequence emits nothing.
// Result channel (empty/pop): sum, position, last of the oldest result.
// Timing: the front takes an item per cycle while the command queue has room.
// The back end writes each append into its store while idle; a run loads its
// lengths, then issues one multiply-accumulate per cycle while the result
// queue has room; the single 32x32 multiplier sets that rate. A result passes
// the store read and product registers, then the result queue, before it is
// on the result ports. When the receiver stalls, the result queue fills, the
// back end holds, then the command queue fills and full rises.
// Reset clears the lengths and both queues; the stores keep old contents.
`include "assert_macros.svh"

module full_linear_convolution_unit #(
	parameter int MAX_LEN    = 32,
	parameter int CMDQ_DEPTH = 4,
	parameter int RESQ_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         func,
	input  logic signed [31:0] sample,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] sum,
	output logic [5:0]         position,
	output logic               last
);
	import flc_pkg::*;

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(res_t);
	localparam int CLW   = $clog2(CMDQ_DEPTH + 1);
	localparam int RLW   = $clog2(RESQ_DEPTH + 1);

	cmd_t             cmd_in, cmd_head;
	logic [CMD_W-1:0] cmd_head_w;
	logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
	logic [CLW-1:0]   cmd_level;

	res_t             res_in, res_out;
	logic [RES_W-1:0] res_out_w;
	logic             res_push, res_full;
	logic [RLW-1:0]   res_level;

	flc_front #(
		.MAX_LEN(MAX_LEN)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.func    (func),
		.sample  (sample),
		.q_full  (cmd_full),
		.cmd_push(cmd_push),
		.cmd     (cmd_in)
	);

	flc_fifo #(
		.W    (CMD_W),
		.DEPTH(CMDQ_DEPTH)
	) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.din   (cmd_in),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.dout  (cmd_head_w),
		.empty (cmd_empty),
		.level (cmd_level)
	);

	assign cmd_head = cmd_t'(cmd_head_w);

	flc_back #(
		.MAX_LEN   (MAX_LEN),
		.RESQ_DEPTH(RESQ_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_head),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_level(res_level),
		.res_push (res_push),
		.res      (res_in)
	);

	flc_fifo #(
		.W    (RES_W),
		.DEPTH(RESQ_DEPTH)
	) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res_in),
		.full  (res_full),
		.pop   (pop),
		.dout  (res_out_w),
		.empty (empty),
		.level (res_level)
	);

	assign res_out  = res_t'(res_out_w);
	assign sum      = res_out.sum;
	assign position = res_out.position;
	assign last     = res_out.last;

	`FLC_ASSERT(a_resq_no_overflow, res_push |-> !res_full, "result pushed into full queue")
	`FLC_ASSERT(a_cmdq_no_overflow, cmd_push |-> !cmd_full, "command pushed into full queue")
	`FLC_ASSERT(a_pop_only_nonempty, cmd_pop |-> (cmd_level != '0), "command popped from empty queue")
	`FLC_ASSERT(a_resq_level, res_level <= RLW'(RESQ_DEPTH), "result level beyond depth")

endmodule

// File: rtl/flc_fifo.sv
// Small synchronous queue with a fill level, used for commands and results.
// Depends on nothing.
module flc_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [W-1:0]               din,
	output logic                       full,
	input  logic                       pop,
	output logic [W-1:0]               dout,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] level
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [LW-1:0] level_q;
	logic          do_push, do_pop;

	assign full    = (level_q == LW'(DEPTH));
	assign empty   = (level_q == '0);
	assign level   = level_q;
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// File: rtl/flc_front.sv
// Front end: accepts items, keeps the sequence lengths, issues commands.
// Depends on flc_pkg.
module flc_front #(
	parameter int MAX_LEN = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [1:0]    func,
	input  logic [31:0]   sample,
	input  logic          q_full,
	output logic          cmd_push,
	output flc_pkg::cmd_t cmd
);
	import flc_pkg::*;

	logic [LEN_W-1:0] f_cnt_q, g_cnt_q;
	logic             take;
	logic             f_room, g_room;

	assign full   = q_full;
	assign take   = push & ~q_full;
	assign f_room = (f_cnt_q < LEN_W'(MAX_LEN));
	assign g_room = (g_cnt_q < LEN_W'(MAX_LEN));

	always_comb begin
		cmd_push  = 1'b0;
		cmd.kind  = CMD_RUN;
		cmd.data  = sample;
		cmd.arg_a = f_cnt_q;
		cmd.arg_b = g_cnt_q;
		unique case (func_t'(func))
			FN_LOAD_F: begin
				cmd.kind = CMD_WR_F;
				cmd_push = take & f_room;
			end
			FN_LOAD_G: begin
				cmd.kind  = CMD_WR_G;
				cmd.arg_a = g_cnt_q;
				cmd_push  = take & g_room;
			end
			FN_RUN: begin
				// drop runs over an empty sequence; counts still clear
				cmd_push = take & (f_cnt_q != '0) & (g_cnt_q != '0);
			end
			default: begin
				cmd_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_cnt_q <= '0;
			g_cnt_q <= '0;
		end else if (take) begin
			case (func_t'(func))
				FN_LOAD_F: if (f_room) f_cnt_q <= f_cnt_q + 1'b1;
				FN_LOAD_G: if (g_room) g_cnt_q <= g_cnt_q + 1'b1;
				FN_RUN: begin
					f_cnt_q <= '0;
					g_cnt_q <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/flc_back.sv
// Back end: sample stores and the multiply-accumulate walker for a run.
// Depends on flc_pkg; fed from the command queue, drains into the result queue.
module flc_back #(
	parameter int MAX_LEN    = 32,
	parameter int RESQ_DEPTH = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  flc_pkg::cmd_t                   cmd,
	input  logic                            cmd_empty,
	output logic                            cmd_pop,
	input  logic [$clog2(RESQ_DEPTH+1)-1:0] res_level,
	output logic                            res_push,
	output flc_pkg::res_t                   res
);
	import flc_pkg::*;

	localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LVW = $clog2(RESQ_DEPTH + 1);
	localparam int CRW = LVW + 1;

	back_state_t state_q, state_d;

	logic [DATA_W-1:0] f_mem [MAX_LEN];
	logic [DATA_W-1:0] g_mem [MAX_LEN];

	logic [LEN_W-1:0] fl_q, gl_q, end_i_q, i_q, j_q;
	logic             first_q;

	logic             wr_f, wr_g, start, issue;
	logic [LEN_W-1:0] hi, i_nx, lo_nx, gidx;
	logic             row_end, run_end, room;
	logic [CRW-1:0]   pending;

	logic              v_s1, first_s1, lastj_s1, end_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [DATA_W-1:0] f_s1, g_s1;
	logic              v_s2, first_s2, lastj_s2, end_s2;
	logic [POS_W-1:0]  pos_s2;
	logic [DATA_W-1:0] prod_s2;
	logic [DATA_W-1:0] acc_q, acc_sum;

	// index window of the current output position
	assign hi      = (i_q < fl_q - 1'b1) ? i_q : fl_q - 1'b1;
	assign row_end = (j_q == hi);
	assign run_end = row_end & (i_q == end_i_q);
	assign i_nx    = i_q + 1'b1;
	assign lo_nx   = (i_nx >= gl_q) ? i_nx + 1'b1 - gl_q : '0;
	assign gidx    = i_q - j_q;

	// results still in the pipe must find a queue slot
	assign pending = CRW'(res_level) + CRW'(v_s1 & lastj_s1) + CRW'(v_s2 & lastj_s2);
	assign room    = (pending < CRW'(RESQ_DEPTH));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (!cmd_empty && cmd.kind == CMD_RUN) state_d = ST_RUN;
			ST_RUN:  if (room && run_end) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop = 1'b0;
		wr_f    = 1'b0;
		wr_g    = 1'b0;
		start   = 1'b0;
		issue   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					case (cmd.kind)
						CMD_WR_F: wr_f = 1'b1;
						CMD_WR_G: wr_g = 1'b1;
						CMD_RUN:  start = 1'b1;
						default: ;
					endcase
				end
			end
			ST_RUN: issue = room;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
		end
	end

	// walker position
	always_ff @(posedge clk) begin
		if (start) begin
			fl_q    <= cmd.arg_a;
			gl_q    <= cmd.arg_b;
			end_i_q <= cmd.arg_a + cmd.arg_b - LEN_W'(2);
			i_q     <= '0;
			j_q     <= '0;
			first_q <= 1'b1;
		end else if (issue) begin
			if (row_end) begin
				i_q     <= i_nx;
				j_q     <= lo_nx;
				first_q <= 1'b1;
			end else begin
				j_q     <= j_q + 1'b1;
				first_q <= 1'b0;
			end
		end
	end

	// stores: one write and one registered read each
	always_ff @(posedge clk) begin
		if (wr_f) f_mem[cmd.arg_a[AW-1:0]] <= cmd.data;
		if (wr_g) g_mem[cmd.arg_a[AW-1:0]] <= cmd.data;
		f_s1 <= f_mem[j_q[AW-1:0]];
		g_s1 <= g_mem[gidx[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		first_s1 <= first_q;
		lastj_s1 <= row_end;
		end_s1   <= run_end;
		pos_s1   <= POS_W'(i_q);
		first_s2 <= first_s1;
		lastj_s2 <= lastj_s1;
		end_s2   <= end_s1;
		pos_s2   <= pos_s1;
		prod_s2  <= f_s1 * g_s1;
		if (v_s2) acc_q <= acc_sum;
	end

	assign acc_sum      = (first_s2 ? '0 : acc_q) + prod_s2;
	assign res_push     = v_s2 & lastj_s2;
	assign res.sum      = acc_sum;
	assign res.position = pos_s2;
	assign res.last     = end_s2;

endmodule
